>>> hw/rtl/sar_pkg.sv
`timescale 1ns / 1ps
package sar_pkg;

  localparam int HDR_LEN  = 40;
  localparam int SEG_LEN  = 40;
  localparam int OPT_LEN  = 20;
  localparam int SUM_W    = 21;
  localparam int IDX_W    = 6;

  localparam logic [7:0]  SYN_FLAG   = 8'h02;
  localparam logic [7:0]  SYNACK     = 8'h12;
  localparam logic [3:0]  DOFF_10    = 4'hA;
  localparam logic [31:0] LFSR_MASK  = 32'h8020_0003;
  localparam logic [15:0] PROTO_TCP  = 16'h0006;

  // register index codes, taken from paddr[2]
  localparam logic REG_TARGET = 1'b0;
  localparam logic REG_SEED   = 1'b1;

  typedef struct packed {
    logic [31:0]      peer;
    logic [15:0]      sport;
    logic [15:0]      dport;
    logic [31:0]      seq;
    logic [31:0]      ack;
    logic [3:0]       rsvd;
    logic [15:0]      window;
    logic [15:0]      urgent;
    logic [SUM_W-1:0] sum;
  } desc_t;

  function automatic logic [7:0] opt_byte(input logic [4:0] i);
    logic [7:0] b;
    case (i)
      5'd0:    b = 8'h02;
      5'd1:    b = 8'h04;
      5'd2:    b = 8'hff;
      5'd3:    b = 8'hd7;
      5'd4:    b = 8'h04;
      5'd5:    b = 8'h02;
      5'd6:    b = 8'h08;
      5'd7:    b = 8'h0a;
      5'd8:    b = 8'h13;
      5'd9:    b = 8'h36;
      5'd10:   b = 8'h7d;
      5'd11:   b = 8'h28;
      5'd16:   b = 8'h01;
      5'd17:   b = 8'h03;
      5'd18:   b = 8'h03;
      5'd19:   b = 8'h07;
      default: b = 8'h00;
    endcase
    return b;
  endfunction

  function automatic logic [SUM_W-1:0] opt_sum();
    logic [SUM_W-1:0] s;
    s = '0;
    for (int i = 0; i < OPT_LEN / 2; i++) begin
      s = s + SUM_W'({opt_byte(5'(2 * i)), opt_byte(5'(2 * i + 1))});
    end
    return s;
  endfunction

  // fixed words: pseudo-header protocol and length, offset/flags word, options
  localparam logic [SUM_W-1:0] SUM_BASE = opt_sum() + SUM_W'(PROTO_TCP)
                                        + SUM_W'(SEG_LEN) + SUM_W'({DOFF_10, 4'h0, SYNACK});

  function automatic logic [31:0] lfsr_next(input logic [31:0] s);
    return s[0] ? ((s >> 1) ^ LFSR_MASK) : (s >> 1);
  endfunction

endpackage

>>> hw/rtl/syn_ack_responder_core.sv
`timescale 1ns / 1ps
// takes one packet byte per cycle; input stalls only when two replies are already queued
// a reply's first byte goes via the queue and desc_r to the output register after byte forty
// a reply streams 40 bytes, one per cycle while out_tready, via the single output byte register
// replies follow with no gap, so 40-byte packets sustain one byte per cycle if out_tready holds
// reset (rst_n, synchronous) clears counters and queue, listen address to 0, seed and lfsr to 1
module syn_ack_responder_core (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [7:0]  in_tdata,    // data_byte
  input  logic        in_tlast,
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [39:0] out_tdata,   // out_byte [7:0], reply_addr [39:8]
  output logic        out_tlast,
  input  logic        cfg_psel,
  input  logic        cfg_penable,
  input  logic        cfg_pwrite,
  input  logic [2:0]  cfg_paddr,
  input  logic [31:0] cfg_pwdata,
  output logic [31:0] cfg_prdata,
  output logic        cfg_pready
);
  import sar_pkg::*;

  logic [31:0] target_r, seed_r;
  logic        wr, seed_load;
  logic        q_full, q_push, q_pop, q_valid;
  desc_t       push_desc, head;

  assign cfg_pready = 1'b1;
  assign wr         = cfg_psel && cfg_penable && cfg_pwrite && cfg_pready;
  assign seed_load  = wr && (cfg_paddr[2] == REG_SEED);
  assign cfg_prdata = (cfg_paddr[2] == REG_SEED) ? seed_r : target_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      target_r <= '0;
      seed_r   <= 32'd1;
    end else if (wr) begin
      if (cfg_paddr[2] == REG_TARGET) begin
        target_r <= cfg_pwdata;
      end else begin
        seed_r <= cfg_pwdata;
      end
    end
  end

  sar_front u_front (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_tvalid   (in_tvalid),
    .in_tready   (in_tready),
    .in_tdata    (in_tdata),
    .in_tlast    (in_tlast),
    .listen_addr (target_r),
    .seed_load   (seed_load),
    .seed_value  (cfg_pwdata),
    .q_full      (q_full),
    .q_push      (q_push),
    .q_desc      (push_desc)
  );

  sar_queue u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (q_push),
    .push_desc (push_desc),
    .full      (q_full),
    .pop       (q_pop),
    .valid     (q_valid),
    .head      (head)
  );

  sar_back u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .q_valid    (q_valid),
    .q_desc     (head),
    .q_pop      (q_pop),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tlast  (out_tlast)
  );

`ifndef SYNTHESIS
  a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
    q_push |-> !q_full || q_pop)
    else $error("reply queue overflow");

  a_no_underflow: assert property (@(posedge clk) disable iff (!rst_n)
    q_pop |-> q_valid)
    else $error("reply queue underflow");

  a_last_ends_reply: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && out_tready && out_tlast) |=> !(out_tvalid && out_tlast))
    else $error("back-to-back last bytes");
`endif

endmodule

>>> hw/rtl/sar_front.sv
`timescale 1ns / 1ps
module sar_front (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          in_tvalid,
  output logic          in_tready,
  input  logic [7:0]    in_tdata,
  input  logic          in_tlast,
  input  logic [31:0]   listen_addr,
  input  logic          seed_load,
  input  logic [31:0]   seed_value,
  input  logic          q_full,
  output logic          q_push,
  output sar_pkg::desc_t q_desc
);
  import sar_pkg::*;

  logic [IDX_W-1:0] cnt_r;
  logic [SUM_W-1:0] sum_r, sum_nxt, term;
  logic [31:0]      peer_r, our_r, rseq_r, ack_r, lfsr_r;
  logic [15:0]      sport_r, dport_r, win_r;
  logic [7:0]       flags_r, urg_hi_r;
  logic [3:0]       nib_r;
  logic             xfer, keep;

  assign in_tready = !((cnt_r == IDX_W'(HDR_LEN - 1)) && q_full);
  assign xfer      = in_tvalid && in_tready;
  assign keep      = xfer && (cnt_r < IDX_W'(HDR_LEN));

  always_comb begin
    term = '0;
    case (cnt_r)
      6'd0:  term = SUM_BASE;
      6'd12, 6'd14, 6'd16, 6'd18, 6'd20, 6'd22, 6'd34, 6'd38: begin
        term = SUM_W'({in_tdata, 8'h00});
      end
      6'd13, 6'd15, 6'd17, 6'd19, 6'd21, 6'd23, 6'd35, 6'd39: begin
        term = SUM_W'(in_tdata);
      end
      6'd29: term = SUM_W'(ack_r[31:16]);
      6'd31: term = SUM_W'(ack_r[15:0]);
      6'd32: term = SUM_W'({in_tdata[3:0], 8'h00});
      default: term = '0;
    endcase
    sum_nxt = (cnt_r == '0) ? term : sum_r + term;
  end

  assign q_push = xfer && (cnt_r == IDX_W'(HDR_LEN - 1)) && (our_r == listen_addr)
                  && (flags_r == SYN_FLAG);

  always_comb begin
    q_desc.peer   = peer_r;
    q_desc.sport  = sport_r;
    q_desc.dport  = dport_r;
    q_desc.seq    = lfsr_r;
    q_desc.ack    = ack_r;
    q_desc.rsvd   = nib_r;
    q_desc.window = win_r;
    q_desc.urgent = {urg_hi_r, in_tdata};
    q_desc.sum    = sum_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= '0;
    end else if (xfer) begin
      if (in_tlast) begin
        cnt_r <= '0;
      end else if (cnt_r < IDX_W'(HDR_LEN)) begin
        cnt_r <= cnt_r + 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      lfsr_r <= 32'd1;
    end else if (seed_load) begin
      lfsr_r <= (seed_value == '0) ? 32'd1 : seed_value;
    end else if (q_push) begin
      lfsr_r <= lfsr_next(lfsr_r);
    end
  end

  always_ff @(posedge clk) begin
    if (keep) begin
      sum_r <= sum_nxt;
      case (cnt_r)
        6'd12, 6'd13, 6'd14, 6'd15: peer_r  <= {peer_r[23:0], in_tdata};
        6'd16, 6'd17, 6'd18, 6'd19: our_r   <= {our_r[23:0], in_tdata};
        6'd20, 6'd21:               sport_r <= {sport_r[7:0], in_tdata};
        6'd22, 6'd23:               dport_r <= {dport_r[7:0], in_tdata};
        6'd24, 6'd25, 6'd26, 6'd27: rseq_r  <= {rseq_r[23:0], in_tdata};
        6'd28:                      ack_r   <= rseq_r + 32'd1;
        6'd32:                      nib_r   <= in_tdata[3:0];
        6'd33:                      flags_r <= in_tdata;
        6'd34, 6'd35:               win_r   <= {win_r[7:0], in_tdata};
        6'd38:                      urg_hi_r <= in_tdata;
        default: ;
      endcase
    end
  end

endmodule

>>> hw/rtl/sar_queue.sv
`timescale 1ns / 1ps
module sar_queue (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           push,
  input  sar_pkg::desc_t push_desc,
  output logic           full,
  input  logic           pop,
  output logic           valid,
  output sar_pkg::desc_t head
);
  import sar_pkg::*;

  desc_t      ent_r [2];
  logic       wp_r, rp_r;
  logic [1:0] cnt_r;

  assign full  = (cnt_r == 2'd2);
  assign valid = (cnt_r != 2'd0);
  assign head  = ent_r[rp_r];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= 1'b0;
      rp_r  <= 1'b0;
      cnt_r <= '0;
    end else begin
      if (push) begin
        wp_r <= ~wp_r;
      end
      if (pop) begin
        rp_r <= ~rp_r;
      end
      case ({push, pop})
        2'b10:   cnt_r <= cnt_r + 2'd1;
        2'b01:   cnt_r <= cnt_r - 2'd1;
        default: cnt_r <= cnt_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      ent_r[wp_r] <= push_desc;
    end
  end

endmodule

>>> hw/rtl/sar_back.sv
`timescale 1ns / 1ps
module sar_back (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           q_valid,
  input  sar_pkg::desc_t q_desc,
  output logic           q_pop,
  output logic           out_tvalid,
  input  logic           out_tready,
  output logic [39:0]    out_tdata,
  output logic           out_tlast
);
  import sar_pkg::*;

  desc_t            desc_r;
  logic             busy_r, ov_r, ol_r;
  logic [IDX_W-1:0] idx_r;
  logic [SUM_W-1:0] csa_r;
  logic [16:0]      csb_r;
  logic [15:0]      ck_r;
  logic [7:0]       ob_r, sel;
  logic [31:0]      oaddr_r;
  logic             out_adv, emit, fin;

  assign out_adv = !ov_r || out_tready;
  assign emit    = busy_r && out_adv;
  assign fin     = emit && (idx_r == IDX_W'(SEG_LEN - 1));
  assign q_pop   = q_valid && (!busy_r || fin);

  always_comb begin
    case (idx_r)
      6'd0:  sel = desc_r.dport[15:8];
      6'd1:  sel = desc_r.dport[7:0];
      6'd2:  sel = desc_r.sport[15:8];
      6'd3:  sel = desc_r.sport[7:0];
      6'd4:  sel = desc_r.seq[31:24];
      6'd5:  sel = desc_r.seq[23:16];
      6'd6:  sel = desc_r.seq[15:8];
      6'd7:  sel = desc_r.seq[7:0];
      6'd8:  sel = desc_r.ack[31:24];
      6'd9:  sel = desc_r.ack[23:16];
      6'd10: sel = desc_r.ack[15:8];
      6'd11: sel = desc_r.ack[7:0];
      6'd12: sel = {DOFF_10, desc_r.rsvd};
      6'd13: sel = SYNACK;
      6'd14: sel = desc_r.window[15:8];
      6'd15: sel = desc_r.window[7:0];
      6'd16: sel = ck_r[15:8];
      6'd17: sel = ck_r[7:0];
      6'd18: sel = desc_r.urgent[15:8];
      6'd19: sel = desc_r.urgent[7:0];
      default: sel = opt_byte(5'(idx_r - 6'd20));
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      ov_r   <= 1'b0;
      idx_r  <= '0;
    end else begin
      if (q_pop) begin
        busy_r <= 1'b1;
      end else if (fin) begin
        busy_r <= 1'b0;
      end
      if (q_pop) begin
        idx_r <= '0;
      end else if (emit) begin
        idx_r <= idx_r + 1'b1;
      end
      if (emit) begin
        ov_r <= 1'b1;
      end else if (out_tready) begin
        ov_r <= 1'b0;
      end
    end
  end

  // checksum settles through csa_r, csb_r and ck_r after load, well before byte sixteen
  always_ff @(posedge clk) begin
    if (q_pop) begin
      desc_r <= q_desc;
      csa_r  <= q_desc.sum + SUM_W'(q_desc.seq[31:16]) + SUM_W'(q_desc.seq[15:0]);
    end
    csb_r <= 17'(csa_r[SUM_W-1:16]) + 17'(csa_r[15:0]);
    ck_r  <= ~(csb_r[15:0] + 16'(csb_r[16]));
    if (emit) begin
      ob_r    <= sel;
      ol_r    <= (idx_r == IDX_W'(SEG_LEN - 1));
      oaddr_r <= desc_r.peer;
    end
  end

  assign out_tvalid = ov_r;
  assign out_tdata  = {oaddr_r, ob_r};
  assign out_tlast  = ol_r;

endmodule

>>> test/tb_top.sv
`timescale 1ns / 1ps
module tb_top;
  import sar_pkg::*;

  typedef struct packed {
    logic [7:0]  seg_byte;
    logic        seg_last;
    logic [31:0] peer_addr;
  } seg_byte_t;

  typedef enum {FILL_RAND, FILL_ZERO, FILL_ONES} fill_t;

  localparam logic [159:0] TCP_OPTIONS =
    160'h0204ffd7_0402080a_13367d28_00000000_01030307;

  logic        clk;
  logic        rst_n;
  logic        in_tvalid;
  logic        in_tready;
  logic [7:0]  in_tdata;    // data_byte
  logic        in_tlast;
  logic        out_tvalid;
  logic        out_tready;
  logic [39:0] out_tdata;   // out_byte [7:0], reply_addr [39:8]
  logic        out_tlast;
  logic        cfg_psel;
  logic        cfg_penable;
  logic        cfg_pwrite;
  logic [2:0]  cfg_paddr;
  logic [31:0] cfg_pwdata;
  logic [31:0] cfg_prdata;
  logic        cfg_pready;

  // responder state as predicted
  logic [31:0] listen_addr;
  logic [31:0] seq_lfsr;
  logic [7:0]  hdr_bytes [0:39];
  int          hdr_cnt;
  seg_byte_t   reply_q [$];

  int          errors;
  bit          calm;

  syn_ack_responder_core i_dut (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_tvalid   (in_tvalid),
    .in_tready   (in_tready),
    .in_tdata    (in_tdata),
    .in_tlast    (in_tlast),
    .out_tvalid  (out_tvalid),
    .out_tready  (out_tready),
    .out_tdata   (out_tdata),
    .out_tlast   (out_tlast),
    .cfg_psel    (cfg_psel),
    .cfg_penable (cfg_penable),
    .cfg_pwrite  (cfg_pwrite),
    .cfg_paddr   (cfg_paddr),
    .cfg_pwdata  (cfg_pwdata),
    .cfg_prdata  (cfg_prdata),
    .cfg_pready  (cfg_pready)
  );

  always begin
    clk = 1'b1;
    #5;
    clk = 1'b0;
    #5;
  end

  task automatic emit_syn_ack();
    logic [7:0]  seg [0:39];
    logic [31:0] our_addr;
    logic [31:0] peer;
    logic [31:0] sum;
    logic [15:0] csum;
    our_addr = {hdr_bytes[16], hdr_bytes[17], hdr_bytes[18], hdr_bytes[19]};
    peer = {hdr_bytes[12], hdr_bytes[13], hdr_bytes[14], hdr_bytes[15]};
    {seg[8], seg[9], seg[10], seg[11]} =
      {hdr_bytes[24], hdr_bytes[25], hdr_bytes[26], hdr_bytes[27]} + 32'd1;
    {seg[4], seg[5], seg[6], seg[7]} = seq_lfsr;
    seg[0] = hdr_bytes[22];
    seg[1] = hdr_bytes[23];
    seg[2] = hdr_bytes[20];
    seg[3] = hdr_bytes[21];
    seg[12] = {DOFF_10, hdr_bytes[32][3:0]};
    seg[13] = SYNACK;
    seg[14] = hdr_bytes[34];
    seg[15] = hdr_bytes[35];
    seg[16] = 8'h00;
    seg[17] = 8'h00;
    seg[18] = hdr_bytes[38];
    seg[19] = hdr_bytes[39];
    for (int i = 20; i < 40; i++) seg[i] = TCP_OPTIONS[159 - 8 * (i - 20) -: 8];
    sum = our_addr[31:16] + our_addr[15:0] + peer[31:16] + peer[15:0]
        + 32'h6 + 32'd40;
    for (int i = 0; i < 40; i += 2) sum = sum + {16'h0, seg[i], seg[i + 1]};
    sum = (sum >> 16) + (sum & 32'hffff);
    sum = sum + (sum >> 16);
    csum = ~sum[15:0];
    seg[16] = csum[15:8];
    seg[17] = csum[7:0];
    seq_lfsr = seq_lfsr[0] ? ((seq_lfsr >> 1) ^ LFSR_MASK) : (seq_lfsr >> 1);
    for (int i = 0; i < 40; i++) reply_q.push_back('{seg[i], i == 39, peer});
  endtask

  task automatic absorb_byte(input logic [7:0] b, input logic l);
    if (hdr_cnt < 40) begin
      hdr_bytes[hdr_cnt] = b;
      hdr_cnt++;
      if (hdr_cnt == 40 && hdr_bytes[33] == SYN_FLAG &&
          {hdr_bytes[16], hdr_bytes[17], hdr_bytes[18], hdr_bytes[19]} == listen_addr) begin
        emit_syn_ack();
      end
    end
    if (l) hdr_cnt = 0;
  endtask

  task automatic send_byte(input logic [7:0] b, input logic l);
    while (!calm && $urandom_range(99) < 18) begin
      in_tvalid = 1'b0;
      @(negedge clk);
    end
    in_tvalid = 1'b1;
    in_tdata = b;
    in_tlast = l;
    do @(posedge clk); while (!in_tready);
    absorb_byte(b, l);
    @(negedge clk);
  endtask

  task automatic send_packet(input int len, input logic [31:0] dst, input logic [7:0] flags,
                             input fill_t fill);
    logic [7:0] b;
    for (int i = 0; i < len; i++) begin
      case (fill)
        FILL_ZERO: b = 8'h00;
        FILL_ONES: b = 8'hff;
        default:   b = 8'($urandom);
      endcase
      if (i >= 16 && i <= 19) b = dst[31 - 8 * (i - 16) -: 8];
      if (i == 33) b = flags;
      send_byte(b, i == len - 1);
    end
  endtask

  task automatic wait_idle();
    in_tvalid = 1'b0;
    while (reply_q.size() != 0) @(negedge clk);
    repeat (8) @(negedge clk);
  endtask

  task automatic cfg_write(input logic reg_sel, input logic [31:0] value);
    wait_idle();
    cfg_psel = 1'b1;
    cfg_penable = 1'b0;
    cfg_pwrite = 1'b1;
    cfg_paddr = {reg_sel, 2'b00};
    cfg_pwdata = value;
    @(negedge clk);
    cfg_penable = 1'b1;
    do @(posedge clk); while (!cfg_pready);
    if (reg_sel == REG_TARGET) listen_addr = value;
    else seq_lfsr = (value == 32'h0) ? 32'h1 : value;
    @(negedge clk);
    cfg_psel = 1'b0;
    cfg_penable = 1'b0;
    cfg_pwrite = 1'b0;
  endtask

  // receiver side backpressure
  always @(negedge clk) begin
    out_tready = calm || ($urandom_range(99) >= 18);
  end

  always @(posedge clk) begin
    seg_byte_t want;
    if (rst_n && out_tvalid && out_tready) begin
      if (reply_q.size() == 0) begin
        errors++;
        if (errors <= 10) $display("unexpected transfer: byte %h last %b addr %h",
                                   out_tdata[7:0], out_tlast, out_tdata[39:8]);
      end else begin
        want = reply_q.pop_front();
        if (want.seg_byte !== out_tdata[7:0] || want.seg_last !== out_tlast ||
            want.peer_addr !== out_tdata[39:8]) begin
          errors++;
          if (errors <= 10) begin
            $display("mismatch: exp byte %h last %b addr %h, got byte %h last %b addr %h",
                     want.seg_byte, want.seg_last, want.peer_addr,
                     out_tdata[7:0], out_tlast, out_tdata[39:8]);
          end
        end
      end
    end
  end

  task automatic test_lengths();
    send_packet(2, listen_addr, SYN_FLAG, FILL_RAND);
    send_packet(1, listen_addr, SYN_FLAG, FILL_RAND);
  endtask

  // reset target of zero, then a long packet right behind it
  task automatic test_back_to_back();
    calm = 1'b1;
    send_packet(40, listen_addr, SYN_FLAG, FILL_ZERO);
    send_packet(41, listen_addr, SYN_FLAG, FILL_RAND);
    wait_idle();
    calm = 1'b0;
  endtask

  task automatic test_field_extremes();
    cfg_write(REG_TARGET, 32'hffff_ffff);
    cfg_write(REG_SEED, 32'h0);
    send_packet(40, 32'hffff_ffff, SYN_FLAG, FILL_ONES);
  endtask

  // byte-swapped destination must not match
  task automatic test_filter();
    cfg_write(REG_TARGET, 32'hc0a8_0117);
    send_packet(40, 32'h1701_a8c0, SYN_FLAG, FILL_RAND);
  endtask

  task automatic test_random();
    repeat (2) begin
      send_packet($urandom_range(6, 1), listen_addr, 8'($urandom), FILL_RAND);
    end
  endtask

  initial begin
    #3_000_000;
    $display("TB_ERROR");
    $finish;
  end

  initial begin
    int guard;
    errors = 0;
    calm = 1'b0;
    rst_n = 1'b0;
    in_tvalid = 1'b0;
    in_tdata = 8'h00;
    in_tlast = 1'b0;
    out_tready = 1'b0;
    cfg_psel = 1'b0;
    cfg_penable = 1'b0;
    cfg_pwrite = 1'b0;
    cfg_paddr = 3'b000;
    cfg_pwdata = 32'h0;
    listen_addr = 32'h0;
    seq_lfsr = 32'h1;
    hdr_cnt = 0;
    repeat (9) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;
    @(negedge clk);

    test_lengths();
    test_back_to_back();
    test_field_extremes();
    test_filter();
    test_random();

    in_tvalid = 1'b0;
    guard = 0;
    while (reply_q.size() != 0 && guard < 20000) begin
      @(negedge clk);
      guard++;
    end
    repeat (10) @(negedge clk);
    if (reply_q.size() != 0) begin
      errors++;
      if (errors <= 10) $display("%0d expected bytes never arrived", reply_q.size());
    end
    if (errors == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule
